/* hw/rtl/yfs_pkg.sv */
// ----------------------------------------------------------------------------
// yfs_pkg
// shared types, field widths and codes of the planar yuv frame store
// ----------------------------------------------------------------------------
package yfs_pkg;

  // default sizes of the store
  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_HEIGHT_DEF  = 256;
  localparam int MAX_FRAMES_DEF  = 4;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed field widths
  localparam int DIM_W    = 9;   // luma width / height registers
  localparam int COUNT_W  = 3;   // frame count register
  localparam int CFG_W    = 9;   // configuration write data
  localparam int COORD_W  = 8;   // column and row
  localparam int FRAME_W  = 2;
  localparam int PLANE_W  = 2;
  localparam int DATA_W   = 16;  // sample ports
  localparam int SIZE_W   = 2 * DIM_W;          // plane width times plane height
  localparam int ROWOFF_W = COORD_W + DIM_W;    // row times plane width
  localparam int OFFS_W   = SIZE_W + FRAME_W + 1; // word offset inside one plane store

  // plane codes
  localparam logic [PLANE_W-1:0] PLANE_LUMA = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_CB   = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_CR   = 2'd2;
  localparam logic [PLANE_W-1:0] PLANE_BAD  = 2'd3;

  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_444  = 2'd1,
    FMT_422  = 2'd2,
    FMT_420  = 2'd3
  } yfs_fmt_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } yfs_op_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FORMAT = 2'd2,
    REG_COUNT  = 2'd3
  } yfs_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_ACCESS,
    S_DONE
  } yfs_state_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    yfs_fmt_t           fmt;
    logic [COUNT_W-1:0] count;
  } yfs_cfg_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [PLANE_W-1:0] plane;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } yfs_req_t;

  typedef struct packed {
    logic              ok;
    logic [OFFS_W-1:0] offs;
  } yfs_acc_t;

endpackage

/* hw/rtl/yfs_addr.sv */
// ----------------------------------------------------------------------------
// yfs_addr
// range check and word offset of one sample request, two steps
// ----------------------------------------------------------------------------
module yfs_addr #(
  parameter int MAX_WIDTH  = yfs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = yfs_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_FRAMES = yfs_pkg::MAX_FRAMES_DEF
) (
  input  logic              clk,
  input  logic              calc_en,
  input  yfs_pkg::yfs_cfg_t cfg,
  input  yfs_pkg::yfs_req_t req,
  output yfs_pkg::yfs_acc_t acc
);

  localparam longint unsigned DEPTH =
    longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) * longint'(MAX_FRAMES);
  localparam int SIZE_W   = yfs_pkg::SIZE_W;
  localparam int ROWOFF_W = yfs_pkg::ROWOFF_W;
  localparam int OFFS_W   = yfs_pkg::OFFS_W;

  logic                             cfg_ok;
  logic [yfs_pkg::DIM_W-1:0]        pw;
  logic [yfs_pkg::DIM_W-1:0]        ph;
  logic                             pass;
  logic [yfs_pkg::SIZE_W-1:0]       size_r;
  logic [yfs_pkg::ROWOFF_W-1:0]     row_off_r;
  logic [yfs_pkg::COORD_W-1:0]      col_r;
  logic [yfs_pkg::FRAME_W-1:0]      frame_r;
  logic                             pass_r;
  logic [yfs_pkg::OFFS_W-1:0]       frame_off;
  logic [yfs_pkg::OFFS_W-1:0]       offs;

  // configuration check
  always_comb begin
    cfg_ok = (cfg.width != '0) && (cfg.height != '0) && (cfg.count != '0)
          && (cfg.fmt != yfs_pkg::FMT_NONE)
          && (32'(cfg.width) <= 32'(MAX_WIDTH))
          && (32'(cfg.height) <= 32'(MAX_HEIGHT))
          && (32'(cfg.count) <= 32'(MAX_FRAMES));
    if ((cfg.fmt == yfs_pkg::FMT_422 || cfg.fmt == yfs_pkg::FMT_420) && cfg.width[0])
      cfg_ok = 1'b0;
    if (cfg.fmt == yfs_pkg::FMT_420 && cfg.height[0])
      cfg_ok = 1'b0;
  end

  // plane dimensions, chroma subsampled by format
  always_comb begin
    pw = cfg.width;
    ph = cfg.height;
    if (req.plane != yfs_pkg::PLANE_LUMA && cfg.fmt != yfs_pkg::FMT_444)
      pw = cfg.width >> 1;
    if (req.plane != yfs_pkg::PLANE_LUMA && cfg.fmt == yfs_pkg::FMT_420)
      ph = cfg.height >> 1;
  end

  assign pass = cfg_ok && (req.plane != yfs_pkg::PLANE_BAD)
             && ({1'b0, req.frame} < cfg.count)
             && ({1'b0, req.col} < pw)
             && ({1'b0, req.row} < ph);

  // first step: the two products
  always_ff @(posedge clk) begin
    if (calc_en) begin
      size_r    <= SIZE_W'(pw) * SIZE_W'(ph);
      row_off_r <= ROWOFF_W'(req.row) * ROWOFF_W'(pw);
      col_r     <= req.col;
      frame_r   <= req.frame;
      pass_r    <= pass;
    end
  end

  // second step: frame base plus line offset plus column
  always_comb begin
    frame_off = '0;
    if (frame_r[0])
      frame_off = frame_off + OFFS_W'(size_r);
    if (frame_r[1])
      frame_off = frame_off + (OFFS_W'(size_r) << 1);
    offs = frame_off + OFFS_W'(row_off_r) + OFFS_W'(col_r);
  end

  assign acc.offs = offs;
  assign acc.ok   = pass_r && (64'(offs) < DEPTH);

endmodule

/* hw/rtl/yfs_mem.sv */
// ----------------------------------------------------------------------------
// yfs_mem
// single port sample memory holding all three planes, registered read
// ----------------------------------------------------------------------------
module yfs_mem #(
  parameter int ADDR_W = 20,
  parameter int WORD_W = yfs_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WORD_W-1:0] wdata,
  output logic [WORD_W-1:0] rdata
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we)
      mem[addr] <= wdata;
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re)
      rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/planar_yuv_frame_store_top.sv */
// ----------------------------------------------------------------------------
// planar_yuv_frame_store_top
// multi-frame planar yuv sample store with 4:4:4, 4:2:2 and 4:2:0 layouts
// ----------------------------------------------------------------------------
// Usage: set frame width, height, pixel format and frame count through the
// cfg_ write port while no request is in flight. Each request on the in_
// channel reads or writes one sample at a frame, plane, column and row and
// returns one result on the out_ channel: the sample read (zero on a write or
// a rejected request) and an ok flag. Plane 3, a frame at or beyond the frame
// count, a coordinate outside the plane or an invalid configuration rejects
// the request and leaves the store untouched.
// Flow: a request accepted in IDLE passes through CALC, ACCESS and DONE;
// no new request is accepted until it leaves DONE. The two-step address unit
// is followed by the registered read of the single-port sample memory.
// The result sits in an output register, so the next request is accepted
// while a result still waits; a stalled receiver holds the next result in
// its final step until the output register frees.
// Reset clears the configuration to zero (invalid) and the control state;
// the sample memory is not cleared and a sample must be written before read.
// ----------------------------------------------------------------------------
module planar_yuv_frame_store_top #(
  parameter int MAX_WIDTH   = yfs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = yfs_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_FRAMES  = yfs_pkg::MAX_FRAMES_DEF,
  parameter int SAMPLE_BITS = yfs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [yfs_pkg::CFG_W-1:0]     cfg_wdata,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [yfs_pkg::FRAME_W-1:0]   in_frame_sel,
  input  logic [yfs_pkg::PLANE_W-1:0]   in_plane_sel,
  input  logic [yfs_pkg::COORD_W-1:0]   in_col,
  input  logic [yfs_pkg::COORD_W-1:0]   in_row,
  input  logic [yfs_pkg::DATA_W-1:0]    in_wdata,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [yfs_pkg::DATA_W-1:0]    out_rdata,
  output logic                          out_ok
);

  localparam int PLANE_AW = $clog2(MAX_WIDTH * MAX_HEIGHT * MAX_FRAMES);
  localparam int MEM_AW   = PLANE_AW + yfs_pkg::PLANE_W;

  yfs_pkg::yfs_cfg_t   cfg_r;
  yfs_pkg::yfs_req_t   req_r;
  yfs_pkg::yfs_op_t    op_r;
  logic [SAMPLE_BITS-1:0] wdata_r;
  yfs_pkg::yfs_acc_t   acc;
  logic                ok_r;
  yfs_pkg::yfs_state_t state_r;
  yfs_pkg::yfs_state_t state_nxt;

  logic                   in_acc;
  logic                   calc_en;
  logic                   mem_we;
  logic                   mem_re;
  logic                   out_load;
  logic [MEM_AW-1:0]      mem_addr;
  logic [SAMPLE_BITS-1:0] mem_rdata;

  logic                       out_valid_r;
  logic [yfs_pkg::DATA_W-1:0] out_rdata_r;
  logic [yfs_pkg::DATA_W-1:0] out_rdata_nxt;
  logic                       out_ok_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (yfs_pkg::yfs_reg_t'(cfg_index))
        yfs_pkg::REG_WIDTH:  cfg_r.width  <= cfg_wdata;
        yfs_pkg::REG_HEIGHT: cfg_r.height <= cfg_wdata;
        yfs_pkg::REG_FORMAT: cfg_r.fmt    <= yfs_pkg::yfs_fmt_t'(cfg_wdata[1:0]);
        yfs_pkg::REG_COUNT:  cfg_r.count  <= cfg_wdata[yfs_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc = in_valid && in_ready;

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r.frame <= in_frame_sel;
      req_r.plane <= in_plane_sel;
      req_r.col   <= in_col;
      req_r.row   <= in_row;
      op_r        <= yfs_pkg::yfs_op_t'(in_op);
      wdata_r     <= in_wdata[SAMPLE_BITS-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      yfs_pkg::S_IDLE:   if (in_acc) state_nxt = yfs_pkg::S_CALC;
      yfs_pkg::S_CALC:   state_nxt = yfs_pkg::S_ACCESS;
      yfs_pkg::S_ACCESS: state_nxt = yfs_pkg::S_DONE;
      yfs_pkg::S_DONE:   if (out_load) state_nxt = yfs_pkg::S_IDLE;
      default:           state_nxt = yfs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= yfs_pkg::S_IDLE;
    else
      state_r <= state_nxt;
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    calc_en  = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      yfs_pkg::S_IDLE: in_ready = 1'b1;
      yfs_pkg::S_CALC: calc_en  = 1'b1;
      yfs_pkg::S_ACCESS: begin
        mem_we = acc.ok && (op_r == yfs_pkg::OP_WRITE);
        mem_re = acc.ok && (op_r == yfs_pkg::OP_READ);
      end
      yfs_pkg::S_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // address unit
  yfs_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_addr (
    .clk     (clk),
    .calc_en (calc_en),
    .cfg     (cfg_r),
    .req     (req_r),
    .acc     (acc)
  );

  // plane selects the top address bits
  assign mem_addr = {req_r.plane, PLANE_AW'(acc.offs)};

  always_ff @(posedge clk) begin
    if (state_r == yfs_pkg::S_ACCESS)
      ok_r <= acc.ok;
  end

  yfs_mem #(
    .ADDR_W (MEM_AW),
    .WORD_W (SAMPLE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (wdata_r),
    .rdata (mem_rdata)
  );

  // result register
  assign out_rdata_nxt = (ok_r && op_r == yfs_pkg::OP_READ)
                       ? yfs_pkg::DATA_W'(mem_rdata) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (out_load)
      out_valid_r <= 1'b1;
    else if (out_ready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rdata_r <= out_rdata_nxt;
      out_ok_r    <= ok_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rdata = out_rdata_r;
  assign out_ok    = out_ok_r;

  // memory writes only for accepted write requests
  a_write_gated: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == yfs_pkg::S_ACCESS) && acc.ok && (op_r == yfs_pkg::OP_WRITE))
    else $error("sample write outside an accepted write request");

  // a rejected request never returns data
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_rdata == '0))
    else $error("rejected request returned nonzero data");

  // fixed walk from request to final step
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ##2 (state_r == yfs_pkg::S_DONE))
    else $error("request did not reach its final step in time");

  // read and write never issued together
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("memory read and write in the same cycle");

endmodule
